// ===== hw/rtl/rms_pkg.sv =====
// Shared constants and types for the block RMS meter.
package rms_pkg;

  localparam int MAX_LEN_DEF = 1024;   // default block length limit
  localparam int SAMPLE_W    = 16;     // Q1.14 sample width
  localparam int SQ_W        = 31;     // square of a magnitude, at most 2^30
  localparam int MEAN_W      = 31;     // mean square, at most 2^30
  localparam int ROOT_W      = 16;     // root, at most 2^15
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int SREM_W      = ROOT_W + 3;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_RESERVE = 3;     // two samples in flight plus the one being taken

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_OUT
  } bk_state_t;

endpackage

// ===== hw/rtl/rms_front.sv =====
// Front end: takes samples, squares them and accumulates per block.
module rms_front
  import rms_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF,
  parameter int CNT_W   = $clog2(MAX_LEN + 1),
  parameter int SUM_W   = 31 + $clog2(MAX_LEN)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [SAMPLE_W-1:0]        in_sample,
  input  logic                       in_last,
  input  logic                       fifo_room,
  output logic                       push,
  output logic [SUM_W+CNT_W:0]       push_data   // {too_long, count, sum}
);

  logic                 take;
  logic [SAMPLE_W-1:0]  mag;
  logic                 counted;

  logic [CNT_W-1:0]     cnt_r, cnt_nxt, cnt_after;
  logic                 ovf_r, ovf_nxt, ovf_after;
  logic [SUM_W-1:0]     sum_r, sum_nxt, sum_new;

  // stage 1: magnitude
  logic                 s1_valid_r;
  logic [SAMPLE_W-1:0]  s1_mag_r;
  logic                 s1_counted_r, s1_last_r, s1_ovf_r;
  logic [CNT_W-1:0]     s1_cnt_r;

  // stage 2: square
  logic                 s2_valid_r;
  logic [SQ_W-1:0]      s2_sq_r;
  logic                 s2_counted_r, s2_last_r, s2_ovf_r;
  logic [CNT_W-1:0]     s2_cnt_r;

  assign in_ready = fifo_room;
  assign take     = in_valid & in_ready;

  assign mag       = in_sample[SAMPLE_W-1] ? SAMPLE_W'(~in_sample + 1'b1) : in_sample;
  assign counted   = (cnt_r != CNT_W'(MAX_LEN));
  assign cnt_after = counted ? CNT_W'(cnt_r + 1'b1) : cnt_r;
  assign ovf_after = ovf_r | ~counted;

  assign sum_new   = s2_counted_r ? SUM_W'(sum_r + SUM_W'(s2_sq_r)) : sum_r;
  assign push      = s2_valid_r & s2_last_r;
  assign push_data = {s2_ovf_r, s2_cnt_r, sum_new};

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    sum_nxt = sum_r;
    if (take) begin
      cnt_nxt = in_last ? '0 : cnt_after;
      ovf_nxt = in_last ? 1'b0 : ovf_after;
    end
    if (s2_valid_r) begin
      sum_nxt = s2_last_r ? '0 : sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      sum_r      <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      ovf_r      <= ovf_nxt;
      sum_r      <= sum_nxt;
      s1_valid_r <= take;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_mag_r     <= mag;
    s1_counted_r <= counted;
    s1_last_r    <= in_last;
    s1_cnt_r     <= cnt_after;
    s1_ovf_r     <= ovf_after;

    s2_sq_r      <= SQ_W'(s1_mag_r * s1_mag_r);
    s2_counted_r <= s1_counted_r;
    s2_last_r    <= s1_last_r;
    s2_cnt_r     <= s1_cnt_r;
    s2_ovf_r     <= s1_ovf_r;
  end

endmodule

// ===== hw/rtl/rms_fifo.sv =====
// Short queue of closed blocks between front and back end.
module rms_fifo
  import rms_pkg::*;
#(
  parameter int DATA_W  = 53,
  parameter int DEPTH   = FIFO_DEPTH,
  parameter int RESERVE = FIFO_RESERVE
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              not_empty,
  output logic              room
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0]  level_r, level_nxt;

  assign pop_data  = mem_r[rd_ptr_r];
  assign not_empty = (level_r != '0);
  assign room      = (level_r <= LVL_W'(DEPTH - RESERVE));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      level_nxt = LVL_W'(level_r + 1'b1);
    end else if (pop && !push) begin
      level_nxt = LVL_W'(level_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/rms_back.sv =====
// Back end: serial divide of sum by count, then serial integer square root.
module rms_back
  import rms_pkg::*;
#(
  parameter int CNT_W = 11,
  parameter int SUM_W = 41
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  blk_valid,
  input  logic [SUM_W+CNT_W:0]  blk_data,   // {too_long, count, sum}
  output logic                  blk_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ROOT_W-1:0]     out_rms,
  output logic                  out_too_long
);

  localparam int STEP_W = $clog2(SUM_W);

  bk_state_t          state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;

  logic [SUM_W-1:0]   quo_r, quo_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]   div_r, div_nxt;
  logic               ovf_r, ovf_nxt;

  logic [RAD_W-1:0]   rad_r, rad_nxt;
  logic [SREM_W-1:0]  srem_r, srem_nxt;
  logic [ROOT_W-1:0]  root_r, root_nxt;
  logic [ROOT_W-1:0]  rms_r, rms_nxt;

  logic [CNT_W:0]     dshift;
  logic               dge;
  logic [SREM_W-1:0]  sshift, strial;
  logic               sge;

  // one quotient bit per cycle
  assign dshift = {rem_r, quo_r[SUM_W-1]};
  assign dge    = (dshift >= {1'b0, div_r});

  // one root bit per cycle
  assign sshift = {srem_r[SREM_W-3:0], rad_r[RAD_W-1:RAD_W-2]};
  assign strial = SREM_W'({root_r, 2'b01});
  assign sge    = (sshift >= strial);

  assign out_valid    = (state_r == BK_OUT);
  assign out_rms      = rms_r;
  assign out_too_long = ovf_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    ovf_nxt   = ovf_r;
    rad_nxt   = rad_r;
    srem_nxt  = srem_r;
    root_nxt  = root_r;
    rms_nxt   = rms_r;
    blk_pop   = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (blk_valid) begin
          blk_pop   = 1'b1;
          quo_nxt   = blk_data[SUM_W-1:0];
          div_nxt   = blk_data[SUM_W+CNT_W-1:SUM_W];
          ovf_nxt   = blk_data[SUM_W+CNT_W];
          rem_nxt   = '0;
          step_nxt  = STEP_W'(SUM_W - 1);
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        rem_nxt = dge ? CNT_W'(dshift - {1'b0, div_r}) : CNT_W'(dshift);
        quo_nxt = {quo_r[SUM_W-2:0], dge};
        step_nxt = STEP_W'(step_r - 1'b1);
        if (step_r == '0) begin
          // zero count gives a zero mean
          rad_nxt   = (div_r == '0) ? '0 : RAD_W'(quo_nxt[MEAN_W-1:0]);
          srem_nxt  = '0;
          root_nxt  = '0;
          step_nxt  = STEP_W'(ROOT_W - 1);
          state_nxt = BK_SQRT;
        end
      end
      BK_SQRT: begin
        srem_nxt = sge ? SREM_W'(sshift - strial) : sshift;
        root_nxt = {root_r[ROOT_W-2:0], sge};
        rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
        step_nxt = STEP_W'(step_r - 1'b1);
        if (step_r == '0) begin
          rms_nxt   = root_nxt;
          state_nxt = BK_OUT;
        end
      end
      BK_OUT: begin
        if (out_ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    ovf_r  <= ovf_nxt;
    rad_r  <= rad_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
    rms_r  <= rms_nxt;
  end

endmodule

// ===== hw/rtl/block_rms_meter.sv =====
// Top level of the block RMS meter.
// Samples (signed Q1.14) are taken at one per clock while the block queue has
// room; tlast closes a block. Squares are accumulated in a front end with
// magnitude and square stages, and each closed block is queued (four entries)
// for the back end, which divides the sum of squares by the sample count one
// quotient bit a cycle and then takes the integer square root one bit a
// cycle. The back end takes a new block only after its last result has been
// accepted, so short blocks are paced by the back end through the queue.
// Samples beyond MAX_LEN in a block are dropped and flag the result as too
// long.
module block_rms_meter
  import rms_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SAMPLE_W-1:0] in_tdata,    // [15:0] sample
  input  logic                in_tlast,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [ROOT_W-1:0]   out_tdata,   // [15:0] rms_value
  output logic                out_tuser    // [0] too_long
);

  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int SUM_W  = 31 + $clog2(MAX_LEN);
  localparam int BLK_W  = SUM_W + CNT_W + 1;

  logic             fifo_room;
  logic             push, pop, not_empty;
  logic [BLK_W-1:0] push_data, pop_data;

  rms_front #(
    .MAX_LEN (MAX_LEN),
    .CNT_W   (CNT_W),
    .SUM_W   (SUM_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata),
    .in_last   (in_tlast),
    .fifo_room (fifo_room),
    .push      (push),
    .push_data (push_data)
  );

  rms_fifo #(
    .DATA_W  (BLK_W),
    .DEPTH   (FIFO_DEPTH),
    .RESERVE (FIFO_RESERVE)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty),
    .room      (fifo_room)
  );

  rms_back #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .blk_valid    (not_empty),
    .blk_data     (pop_data),
    .blk_pop      (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_rms      (out_tdata),
    .out_too_long (out_tuser)
  );

endmodule
